// File: sv/line_follow_pid_steering_core_macros.svh
// ----------------------------------------------------------------------------
// Line follower steering core: assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, held off in reset.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOW_PID_STEERING_CORE_MACROS_SVH
`define LINE_FOLLOW_PID_STEERING_CORE_MACROS_SVH

// same-cycle implication
`define LFPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LFPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lfps_pkg.sv
// ----------------------------------------------------------------------------
// lfps_pkg
// Types and constants of the line follower PID steering core.
// ----------------------------------------------------------------------------
package lfps_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned BandW   = 15;
  localparam int unsigned GainW   = 16;
  localparam int unsigned CvW     = 16;
  localparam int unsigned DirW    = 4;
  localparam int unsigned ErrW    = SampleW + 1;
  localparam int unsigned DiffW   = ErrW + 1;
  localparam int unsigned PaddrW  = 5;
  localparam int unsigned PdataW  = 32;
  localparam int unsigned RegIdxW = 3;

  // register indexes
  localparam logic [RegIdxW-1:0] RegThreshold = 3'd0;
  localparam logic [RegIdxW-1:0] RegBand      = 3'd1;
  localparam logic [RegIdxW-1:0] RegGainP     = 3'd2;
  localparam logic [RegIdxW-1:0] RegGainI     = 3'd3;
  localparam logic [RegIdxW-1:0] RegGainD     = 3'd4;
  localparam logic [RegIdxW-1:0] RegFullSpeed = 3'd5;
  localparam logic [RegIdxW-1:0] RegRevSpeed  = 3'd6;

  // reset values
  localparam logic [SampleW-1:0]      ThresholdRst = 8'd50;
  localparam logic [BandW-1:0]        BandRst      = 15'd50;
  localparam logic signed [GainW-1:0] GainPRst     = 16'sd256;
  localparam logic signed [GainW-1:0] GainIRst     = 16'sd0;
  localparam logic signed [GainW-1:0] GainDRst     = 16'sd0;
  localparam logic [SampleW-1:0]      FullSpeedRst = 8'd255;
  localparam logic [SampleW-1:0]      RevSpeedRst  = 8'd75;

  // direction codes
  localparam logic [DirW-1:0] DirFwd       = 4'h6;
  localparam logic [DirW-1:0] DirBack      = 4'h9;
  localparam logic [DirW-1:0] DirHardLeft  = 4'h5;
  localparam logic [DirW-1:0] DirHardRight = 4'hA;
  localparam logic [DirW-1:0] DirSoftLeft  = 4'h4;
  localparam logic [DirW-1:0] DirSoftRight = 4'h2;

  typedef struct packed {
    logic [SampleW-1:0] left_sample;
    logic [SampleW-1:0] center_sample;
    logic [SampleW-1:0] right_sample;
  } in_item_t;

  typedef struct packed {
    logic [DirW-1:0]        motor_direction;
    logic [SampleW-1:0]     left_speed;
    logic [SampleW-1:0]     right_speed;
    logic                   marker_seen;
    logic signed [CvW-1:0]  control_value;
  } out_item_t;

  typedef struct packed {
    logic [SampleW-1:0]      threshold;
    logic [BandW-1:0]        band;
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic [SampleW-1:0]      full_speed;
    logic [SampleW-1:0]      reverse_speed;
  } cfg_t;

  // sample-derived decisions carried along the pipeline
  typedef struct packed {
    logic both_sides;
    logic marker;
    logic on_center;
  } flags_t;

endpackage

// File: sv/lfps_regs.sv
// ----------------------------------------------------------------------------
// lfps_regs
// APB register file holding the threshold, band, gains and wheel duties.
// ----------------------------------------------------------------------------
module lfps_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfps_pkg::PaddrW-1:0] paddr,
  input  logic [lfps_pkg::PdataW-1:0] pwdata,
  output logic [lfps_pkg::PdataW-1:0] prdata,
  output logic                        pready,
  output lfps_pkg::cfg_t              cfg_o
);

  lfps_pkg::cfg_t                      cfg_q, cfg_d;
  logic [lfps_pkg::RegIdxW-1:0]        idx;
  logic                                wr_en;

  assign idx    = paddr[lfps_pkg::PaddrW-1:2];
  assign wr_en  = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        lfps_pkg::RegThreshold: cfg_d.threshold     = pwdata[7:0];
        lfps_pkg::RegBand:      cfg_d.band          = pwdata[14:0];
        lfps_pkg::RegGainP:     cfg_d.gain_p        = pwdata[15:0];
        lfps_pkg::RegGainI:     cfg_d.gain_i        = pwdata[15:0];
        lfps_pkg::RegGainD:     cfg_d.gain_d        = pwdata[15:0];
        lfps_pkg::RegFullSpeed: cfg_d.full_speed    = pwdata[7:0];
        lfps_pkg::RegRevSpeed:  cfg_d.reverse_speed = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold     <= lfps_pkg::ThresholdRst;
      cfg_q.band          <= lfps_pkg::BandRst;
      cfg_q.gain_p        <= lfps_pkg::GainPRst;
      cfg_q.gain_i        <= lfps_pkg::GainIRst;
      cfg_q.gain_d        <= lfps_pkg::GainDRst;
      cfg_q.full_speed    <= lfps_pkg::FullSpeedRst;
      cfg_q.reverse_speed <= lfps_pkg::RevSpeedRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      lfps_pkg::RegThreshold: prdata = {24'd0, cfg_q.threshold};
      lfps_pkg::RegBand:      prdata = {17'd0, cfg_q.band};
      lfps_pkg::RegGainP:     prdata = {{16{cfg_q.gain_p[15]}}, cfg_q.gain_p};
      lfps_pkg::RegGainI:     prdata = {{16{cfg_q.gain_i[15]}}, cfg_q.gain_i};
      lfps_pkg::RegGainD:     prdata = {{16{cfg_q.gain_d[15]}}, cfg_q.gain_d};
      lfps_pkg::RegFullSpeed: prdata = {24'd0, cfg_q.full_speed};
      lfps_pkg::RegRevSpeed:  prdata = {24'd0, cfg_q.reverse_speed};
      default:                prdata = '0;
    endcase
  end

endmodule

// File: sv/lfps_front.sv
// ----------------------------------------------------------------------------
// lfps_front
// Input stage: error, derivative, integral snapshot and sample flags.
// Holds the controller state, updated as each item is taken.
// ----------------------------------------------------------------------------
module lfps_front #(
  parameter int unsigned IW = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lfps_pkg::cfg_t                    cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  lfps_pkg::in_item_t                in_item_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [lfps_pkg::ErrW-1:0]  err_o,
  output logic signed [lfps_pkg::DiffW-1:0] diff_o,
  output logic signed [IW-1:0]              sum_o,
  output lfps_pkg::flags_t                  flags_o
);

  logic                              valid_q;
  logic                              take;
  logic signed [lfps_pkg::ErrW-1:0]  err_d, err_q;
  logic signed [lfps_pkg::DiffW-1:0] diff_d, diff_q;
  logic signed [IW-1:0]              sum_q, sum_d, snap_q;
  logic signed [IW:0]                sum_ext;
  logic signed [lfps_pkg::ErrW-1:0]  last_err_q;
  logic [lfps_pkg::SampleW-1:0]      last_l_q, last_c_q, last_r_q;
  logic [lfps_pkg::SampleW-1:0]      l, c, r, thr;
  lfps_pkg::flags_t                  flags_d, flags_q;

  assign in_ready_o = !valid_q || ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign valid_o    = valid_q;
  assign err_o      = err_q;
  assign diff_o     = diff_q;
  assign sum_o      = snap_q;
  assign flags_o    = flags_q;

  assign l   = in_item_i.left_sample;
  assign c   = in_item_i.center_sample;
  assign r   = in_item_i.right_sample;
  assign thr = cfg_i.threshold;

  always_comb begin
    err_d  = $signed({1'b0, l}) - $signed({1'b0, r});
    diff_d = $signed({err_d[lfps_pkg::ErrW-1], err_d})
           - $signed({last_err_q[lfps_pkg::ErrW-1], last_err_q});
    sum_ext = $signed({sum_q[IW-1], sum_q})
            + $signed({{(IW + 1 - lfps_pkg::ErrW){err_d[lfps_pkg::ErrW-1]}}, err_d});
    if (sum_ext[IW] != sum_ext[IW-1]) begin
      sum_d = sum_ext[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end else begin
      sum_d = sum_ext[IW-1:0];
    end
    flags_d.both_sides = (l > thr) && (r > thr);
    flags_d.marker     = (l < thr) && (r < thr) && (c < thr) && (last_l_q < thr)
                      && (last_r_q < thr) && (last_c_q > thr);
    flags_d.on_center  = c > thr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      sum_q      <= '0;
      last_err_q <= '0;
      last_l_q   <= '0;
      last_c_q   <= '0;
      last_r_q   <= '0;
    end else begin
      if (take) begin
        valid_q    <= 1'b1;
        sum_q      <= sum_d;
        last_err_q <= err_d;
        last_l_q   <= l;
        last_c_q   <= c;
        last_r_q   <= r;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      err_q   <= err_d;
      diff_q  <= diff_d;
      snap_q  <= sum_q;
      flags_q <= flags_d;
    end
  end

endmodule

// File: sv/lfps_mult.sv
// ----------------------------------------------------------------------------
// lfps_mult
// Product stage: P, D and split I products, each registered.
// ----------------------------------------------------------------------------
module lfps_mult #(
  parameter int unsigned IW = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lfps_pkg::cfg_t                        cfg_i,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [lfps_pkg::ErrW-1:0]      err_i,
  input  logic signed [lfps_pkg::DiffW-1:0]     diff_i,
  input  logic signed [IW-1:0]                  sum_i,
  input  lfps_pkg::flags_t                      flags_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic signed [lfps_pkg::GainW+lfps_pkg::ErrW-1:0]  pp_o,
  output logic signed [lfps_pkg::GainW+lfps_pkg::DiffW-1:0] pd_o,
  output logic signed [lfps_pkg::GainW+IW/2:0]              pi_lo_o,
  output logic signed [lfps_pkg::GainW+IW-IW/2-1:0]         pi_hi_o,
  output lfps_pkg::flags_t                      flags_o
);

  localparam int unsigned LoW = IW / 2;
  localparam int unsigned HiW = IW - LoW;
  localparam int unsigned GW  = lfps_pkg::GainW;

  logic                                    valid_q, take;
  logic signed [GW-1:0]                    gp, gi, gd;
  logic signed [LoW:0]                     sum_lo;
  logic signed [HiW-1:0]                   sum_hi;
  logic signed [GW+lfps_pkg::ErrW-1:0]     pp_d, pp_q;
  logic signed [GW+lfps_pkg::DiffW-1:0]    pd_d, pd_q;
  logic signed [GW+LoW:0]                  lo_d, lo_q;
  logic signed [GW+HiW-1:0]                hi_d, hi_q;
  lfps_pkg::flags_t                        flags_q;

  assign ready_o = !valid_q || ready_i;
  assign take    = valid_i && ready_o;
  assign valid_o = valid_q;

  assign gp     = cfg_i.gain_p;
  assign gi     = cfg_i.gain_i;
  assign gd     = cfg_i.gain_d;
  assign sum_lo = $signed({1'b0, sum_i[LoW-1:0]});
  assign sum_hi = $signed(sum_i[IW-1:LoW]);

  assign pp_d = gp * err_i;
  assign pd_d = gd * diff_i;
  assign lo_d = gi * sum_lo;
  assign hi_d = gi * sum_hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pp_q    <= pp_d;
      pd_q    <= pd_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      flags_q <= flags_i;
    end
  end

  assign pp_o    = pp_q;
  assign pd_o    = pd_q;
  assign pi_lo_o = lo_q;
  assign pi_hi_o = hi_q;
  assign flags_o = flags_q;

endmodule

// File: sv/lfps_decide.sv
// ----------------------------------------------------------------------------
// lfps_decide
// Result stage: PID sum, band test, steering choice and output register.
// ----------------------------------------------------------------------------
module lfps_decide #(
  parameter int unsigned IW = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lfps_pkg::cfg_t                        cfg_i,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [lfps_pkg::GainW+lfps_pkg::ErrW-1:0]  pp_i,
  input  logic signed [lfps_pkg::GainW+lfps_pkg::DiffW-1:0] pd_i,
  input  logic signed [lfps_pkg::GainW+IW/2:0]              pi_lo_i,
  input  logic signed [lfps_pkg::GainW+IW-IW/2-1:0]         pi_hi_i,
  input  lfps_pkg::flags_t                      flags_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output lfps_pkg::out_item_t                   out_item_o
);

  localparam int unsigned LoW = IW / 2;
  localparam int unsigned AW  = IW + 18;

  logic                     valid_q, take;
  logic signed [AW-1:0]     pp_x, pd_x, lo_x, hi_x, acc, bandq, nbandq;
  logic                     in_band, above, sat_hi, sat_lo;
  logic signed [lfps_pkg::CvW-1:0] cv;
  lfps_pkg::out_item_t      item_d, item_q;
  logic [lfps_pkg::SampleW-1:0] spd;

  assign ready_o     = !valid_q || out_ready_i;
  assign take        = valid_i && ready_o;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_comb begin
    pp_x   = AW'(pp_i);
    pd_x   = AW'(pd_i);
    lo_x   = AW'(pi_lo_i);
    hi_x   = AW'(pi_hi_i);
    acc    = (hi_x <<< LoW) + lo_x + pp_x + pd_x;
    bandq  = $signed({{(AW - lfps_pkg::BandW - 8){1'b0}}, cfg_i.band, 8'd0});
    nbandq = -bandq;
    in_band = (acc > nbandq) && (acc < bandq);
    above   = acc > bandq;
    sat_hi  = !acc[AW-1] && (|acc[AW-2:23]);
    sat_lo  = acc[AW-1] && !(&acc[AW-2:23]);
    if (sat_hi) begin
      cv = 16'sh7FFF;
    end else if (sat_lo) begin
      cv = 16'sh8000;
    end else begin
      cv = acc[23:8];
    end

    spd                   = cfg_i.full_speed;
    item_d.marker_seen    = 1'b0;
    item_d.control_value  = cv;
    if (flags_i.both_sides) begin
      item_d.motor_direction = lfps_pkg::DirFwd;
    end else if (flags_i.marker) begin
      item_d.motor_direction = lfps_pkg::DirFwd;
      item_d.marker_seen     = 1'b1;
    end else if (in_band) begin
      if (flags_i.on_center) begin
        item_d.motor_direction = lfps_pkg::DirFwd;
      end else begin
        item_d.motor_direction = lfps_pkg::DirBack;
        spd                    = cfg_i.reverse_speed;
      end
    end else if (above) begin
      item_d.motor_direction = flags_i.on_center ? lfps_pkg::DirHardLeft
                                                 : lfps_pkg::DirSoftLeft;
    end else begin
      item_d.motor_direction = flags_i.on_center ? lfps_pkg::DirHardRight
                                                 : lfps_pkg::DirSoftRight;
    end
    item_d.left_speed  = spd;
    item_d.right_speed = spd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

// File: sv/line_follow_pid_steering_core.sv
// ----------------------------------------------------------------------------
// line_follow_pid_steering_core
// Line follower steering with a PID term on left minus right sensor error.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i / in_ready_o / in_item_i) takes one sensor triple
//   per item; out channel (out_valid_o / out_ready_i / out_item_o) returns one
//   steering item per input item, in order.
//   From the accepting edge to out_valid_o an item passes three register
//   stages, the first loaded at the accept. Input stage (error, derivative,
//   integral update), product stage (three gain multiplies, integral product
//   split in two halves), result stage (sum, band test, direction choice).
//   Throughput is one item per cycle while out_ready_i is high; every stage
//   has its own valid and advances whenever the stage after it is empty or
//   draining. When the receiver stalls, items fill the three stages, then
//   in_ready_o drops; nothing is lost or repeated. Reset clears the integral,
//   the previous error and previous samples and loads the register defaults.
//   Write the APB port only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module line_follow_pid_steering_core #(
  parameter int unsigned INTEGRAL_WIDTH = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  lfps_pkg::in_item_t          in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lfps_pkg::out_item_t         out_item_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfps_pkg::PaddrW-1:0] paddr,
  input  logic [lfps_pkg::PdataW-1:0] pwdata,
  output logic [lfps_pkg::PdataW-1:0] prdata,
  output logic                        pready
);

`include "line_follow_pid_steering_core_macros.svh"

  localparam int unsigned IW  = INTEGRAL_WIDTH;
  localparam int unsigned LoW = IW / 2;
  localparam int unsigned HiW = IW - LoW;
  localparam int unsigned GW  = lfps_pkg::GainW;

  lfps_pkg::cfg_t                         cfg;
  logic                                   s1_valid, s1_ready;
  logic signed [lfps_pkg::ErrW-1:0]       s1_err;
  logic signed [lfps_pkg::DiffW-1:0]      s1_diff;
  logic signed [IW-1:0]                   s1_sum;
  lfps_pkg::flags_t                       s1_flags;
  logic                                   s2_valid, s2_ready;
  logic signed [GW+lfps_pkg::ErrW-1:0]    s2_pp;
  logic signed [GW+lfps_pkg::DiffW-1:0]   s2_pd;
  logic signed [GW+LoW:0]                 s2_lo;
  logic signed [GW+HiW-1:0]               s2_hi;
  lfps_pkg::flags_t                       s2_flags;

  lfps_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lfps_front #(.IW(IW)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .valid_o    (s1_valid),
    .ready_i    (s1_ready),
    .err_o      (s1_err),
    .diff_o     (s1_diff),
    .sum_o      (s1_sum),
    .flags_o    (s1_flags)
  );

  lfps_mult #(.IW(IW)) u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .err_i   (s1_err),
    .diff_i  (s1_diff),
    .sum_i   (s1_sum),
    .flags_i (s1_flags),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .pp_o    (s2_pp),
    .pd_o    (s2_pd),
    .pi_lo_o (s2_lo),
    .pi_hi_o (s2_hi),
    .flags_o (s2_flags)
  );

  lfps_decide #(.IW(IW)) u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (s2_valid),
    .ready_o     (s2_ready),
    .pp_i        (s2_pp),
    .pd_i        (s2_pd),
    .pi_lo_i     (s2_lo),
    .pi_hi_i     (s2_hi),
    .flags_i     (s2_flags),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  `LFPS_ASSERT_SAME(a_marker_fwd, out_valid_o && out_item_o.marker_seen, out_item_o.motor_direction == lfps_pkg::DirFwd, "marker item not forward")
  `LFPS_ASSERT_SAME(a_back_speed, out_valid_o && (out_item_o.motor_direction == lfps_pkg::DirBack), out_item_o.left_speed == cfg.reverse_speed, "reverse item without reverse duty")
  `LFPS_ASSERT_SAME(a_same_speed, out_valid_o, out_item_o.left_speed == out_item_o.right_speed, "wheel duties differ")
  `LFPS_ASSERT_NEXT(a_stage_fill, s2_valid && !s2_ready, out_valid_o, "result stage empty while product stage blocked")

endmodule
